@@ rtl/core/rfw_pkg.sv @@
package rfw_pkg;

    // Default widths of the coordinate fields and of the internal address path.
    localparam int CoordWidth   = 12;
    localparam int AddrWidth    = 32;

    // Configuration port geometry: three 32-bit registers at byte offsets 0, 4 and 8.
    localparam int RegAddrWidth = 4;
    localparam int RegIdxWidth  = 2;
    localparam int DataWidth    = 32;
    localparam int StrideWidth  = 16;

    localparam logic [RegIdxWidth-1:0] REG_FRAME_BASE   = 2'd0;
    localparam logic [RegIdxWidth-1:0] REG_LINE_STRIDE  = 2'd1;
    localparam logic [RegIdxWidth-1:0] REG_PIXEL_FORMAT = 2'd2;

    // Item kinds on the input channel.
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    // Pixel format; its code doubles as the write size code (log2 of bytes).
    typedef enum logic [1:0] {
        FMT_8BPP  = 2'd0,
        FMT_16BPP = 2'd1,
        FMT_32BPP = 2'd2,
        FMT_NONE  = 2'd3
    } t_pix_fmt;

    typedef struct packed {
        logic [DataWidth-1:0]   frame_base;
        logic [StrideWidth-1:0] line_stride;
        t_pix_fmt               pixel_format;
    } t_cfg;

    // RGB565 field positions within a 0x00RRGGBB word.
    localparam int RedShift   = 16 + 3;
    localparam int GreenShift = 8 + 2;
    localparam int BlueShift  = 3;
    localparam logic [4:0] Mask5 = 5'h1f;
    localparam logic [5:0] Mask6 = 6'h3f;

    // Converts a colour word into the right-aligned pixel value of a format.
    function automatic logic [DataWidth-1:0] pixel_value(t_pix_fmt fmt,
                                                         logic [DataWidth-1:0] color);
        logic [4:0] red;
        logic [5:0] green;
        logic [4:0] blue;
        logic [DataWidth-1:0] value;
        red   = color[RedShift +: 5] & Mask5;
        green = color[GreenShift +: 6] & Mask6;
        blue  = color[BlueShift +: 5] & Mask5;
        case (fmt)
            FMT_8BPP:  value = {24'b0, color[7:0]};
            FMT_16BPP: value = {16'b0, red, green, blue};
            default:   value = color;
        endcase
        return value;
    endfunction

endpackage

@@ rtl/core/rfw_if.sv @@
// Rectangle command channel: start and step beats.
interface rfw_in_if #(
    parameter int COORD_WIDTH = rfw_pkg::CoordWidth
);
    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic [COORD_WIDTH-1:0] left_x;
    logic [COORD_WIDTH-1:0] top_y;
    logic [COORD_WIDTH-1:0] right_x;
    logic [COORD_WIDTH-1:0] bottom_y;
    logic [31:0]            fill_color;

    modport source (output valid, mode, left_x, top_y, right_x, bottom_y, fill_color,
                    input ready);
    modport sink   (input valid, mode, left_x, top_y, right_x, bottom_y, fill_color,
                    output ready);
endinterface

// Pixel write channel.
interface rfw_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] write_addr;
    logic [31:0] write_data;
    logic [1:0]  write_size;
    logic        is_last;

    modport source (output valid, write_addr, write_data, write_size, is_last,
                    input ready);
    modport sink   (input valid, write_addr, write_data, write_size, is_last,
                    output ready);
endinterface

@@ rtl/core/rfw_apb_regs.sv @@
// Configuration registers behind a simple APB slave with zero wait states.
module rfw_apb_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rfw_pkg::RegAddrWidth-1:0]  paddr,
    input  logic [rfw_pkg::DataWidth-1:0]     pwdata,
    output logic [rfw_pkg::DataWidth-1:0]     prdata,
    output logic                              pready,
    output rfw_pkg::t_cfg                     o_cfg
);

    rfw_pkg::t_cfg                     r_cfg;
    rfw_pkg::t_cfg                     n_cfg;
    logic [rfw_pkg::RegIdxWidth-1:0]   w_idx;
    logic                              w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[rfw_pkg::RegAddrWidth-1:2];
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                rfw_pkg::REG_FRAME_BASE:   n_cfg.frame_base   = pwdata;
                rfw_pkg::REG_LINE_STRIDE:  n_cfg.line_stride  =
                    pwdata[rfw_pkg::StrideWidth-1:0];
                rfw_pkg::REG_PIXEL_FORMAT: n_cfg.pixel_format =
                    rfw_pkg::t_pix_fmt'(pwdata[1:0]);
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_base   <= '0;
            r_cfg.line_stride  <= '0;
            r_cfg.pixel_format <= rfw_pkg::FMT_8BPP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_idx)
            rfw_pkg::REG_FRAME_BASE:   prdata = r_cfg.frame_base;
            rfw_pkg::REG_LINE_STRIDE:  prdata = {16'b0, r_cfg.line_stride};
            rfw_pkg::REG_PIXEL_FORMAT: prdata = {30'b0, r_cfg.pixel_format};
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/rectangle_fill_writer_core.sv @@
// Channel   Role        Beat contents
// i_pix     sink        mode, left_x, top_y, right_x, bottom_y, fill_color
// o_wr      source      write_addr, write_data, write_size, is_last
// APB       slave       frame_base @0x0, line_stride @0x4, pixel_format @0x8
//
// Every beat on i_pix is handled in the cycle it is accepted, so one beat per cycle is
// taken unless o_wr stalls; a step beat shows up on o_wr in the cycle after acceptance.
// The only long path is the start address: one 12x16 multiply followed by a 3-term add.
// i_pix.ready stays high while the output register is empty or being drained.
// A stalled o_wr holds its beat and blocks i_pix only for as long as it stays stalled.
// Reset (synchronous, active low) clears the fill and the output register, no sweep.
module rectangle_fill_writer_core #(
    parameter int COORD_WIDTH = rfw_pkg::CoordWidth,
    parameter int ADDR_WIDTH  = rfw_pkg::AddrWidth
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rfw_in_if.sink                            i_pix,
    rfw_out_if.source                         o_wr,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rfw_pkg::RegAddrWidth-1:0]  paddr,
    input  logic [rfw_pkg::DataWidth-1:0]     pwdata,
    output logic [rfw_pkg::DataWidth-1:0]     prdata,
    output logic                              pready
);

    // Full width of a row index times the stride, before wrapping to the address width.
    localparam int RowOffWidth = COORD_WIDTH + rfw_pkg::StrideWidth;

    rfw_pkg::t_cfg w_cfg;

    rfw_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Fill state. The cursor walks the rectangle; r_pix_addr follows it.
    logic                   r_busy,      n_busy;
    logic [COORD_WIDTH-1:0] r_cur_col,   n_cur_col;
    logic [COORD_WIDTH-1:0] r_cur_row,   n_cur_row;
    logic [COORD_WIDTH-1:0] r_first_col, n_first_col;
    logic [COORD_WIDTH-1:0] r_last_col,  n_last_col;
    logic [COORD_WIDTH-1:0] r_last_row,  n_last_row;
    logic [31:0]            r_pix_word,  n_pix_word;
    logic [ADDR_WIDTH-1:0]  r_row_addr,  n_row_addr;
    logic [ADDR_WIDTH-1:0]  r_pix_addr,  n_pix_addr;
    rfw_pkg::t_pix_fmt      r_size,      n_size;

    // Output register that holds one write beat.
    logic                   r_out_valid, n_out_valid;
    logic [31:0]            r_out_addr,  n_out_addr;
    logic [31:0]            r_out_data,  n_out_data;
    logic [1:0]             r_out_size,  n_out_size;
    logic                   r_out_last,  n_out_last;

    logic                   w_accept;
    logic                   w_start;
    logic                   w_start_ok;
    logic                   w_produce;
    logic                   w_row_end;
    logic                   w_last;
    logic [RowOffWidth-1:0] w_row_off;
    logic [ADDR_WIDTH-1:0]  w_start_addr;
    logic [ADDR_WIDTH+31:0] w_addr_ext;

    assign i_pix.ready = !r_out_valid || o_wr.ready;
    assign w_accept    = i_pix.valid && i_pix.ready;
    assign w_start     = w_accept && (i_pix.mode == rfw_pkg::MODE_START);
    assign w_produce   = w_accept && (i_pix.mode == rfw_pkg::MODE_STEP) && r_busy;

    // A start arms the fill only for a supported format and a non-empty rectangle.
    assign w_start_ok = (w_cfg.pixel_format != rfw_pkg::FMT_NONE)
                     && (i_pix.right_x >= i_pix.left_x)
                     && (i_pix.bottom_y >= i_pix.top_y);

    // The product keeps every bit of top * stride so nothing is lost before the wrap.
    assign w_row_off = RowOffWidth'(i_pix.top_y) * RowOffWidth'(w_cfg.line_stride);

    // First pixel address: base + top * stride + left * bytes per pixel, wrapping at the
    // address width.
    assign w_start_addr = ADDR_WIDTH'(w_cfg.frame_base)
                        + ADDR_WIDTH'(w_row_off)
                        + (ADDR_WIDTH'(i_pix.left_x) << w_cfg.pixel_format);

    assign w_row_end  = (r_cur_col == r_last_col);
    assign w_last     = w_row_end && (r_cur_row == r_last_row);

    // The bus address is the low 32 bits, zero extended for narrow address paths.
    assign w_addr_ext = {32'b0, r_pix_addr};

    always_comb begin
        n_busy      = r_busy;
        n_cur_col   = r_cur_col;
        n_cur_row   = r_cur_row;
        n_first_col = r_first_col;
        n_last_col  = r_last_col;
        n_last_row  = r_last_row;
        n_pix_word  = r_pix_word;
        n_row_addr  = r_row_addr;
        n_pix_addr  = r_pix_addr;
        n_size      = r_size;
        if (w_start) begin
            // A new start always abandons whatever fill was pending.
            n_busy      = w_start_ok;
            n_cur_col   = i_pix.left_x;
            n_cur_row   = i_pix.top_y;
            n_first_col = i_pix.left_x;
            n_last_col  = i_pix.right_x;
            n_last_row  = i_pix.bottom_y;
            n_pix_word  = rfw_pkg::pixel_value(w_cfg.pixel_format, i_pix.fill_color);
            n_row_addr  = w_start_addr;
            n_pix_addr  = w_start_addr;
            n_size      = w_cfg.pixel_format;
        end else if (w_produce) begin
            if (w_last) begin
                n_busy = 1'b0;
            end else if (w_row_end) begin
                // The stride is sampled at each row change, not at start.
                n_cur_row  = r_cur_row + 1'b1;
                n_cur_col  = r_first_col;
                n_row_addr = r_row_addr + ADDR_WIDTH'(w_cfg.line_stride);
                n_pix_addr = r_row_addr + ADDR_WIDTH'(w_cfg.line_stride);
            end else begin
                n_cur_col  = r_cur_col + 1'b1;
                n_pix_addr = r_pix_addr + (ADDR_WIDTH'(1) << r_size);
            end
        end
    end

    always_comb begin
        n_out_addr = r_out_addr;
        n_out_data = r_out_data;
        n_out_size = r_out_size;
        n_out_last = r_out_last;
        if (w_produce) begin
            n_out_valid = 1'b1;
            n_out_addr  = w_addr_ext[31:0];
            n_out_data  = r_pix_word;
            n_out_size  = r_size;
            n_out_last  = w_last;
        end else if (o_wr.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_col   <= n_cur_col;
        r_cur_row   <= n_cur_row;
        r_first_col <= n_first_col;
        r_last_col  <= n_last_col;
        r_last_row  <= n_last_row;
        r_pix_word  <= n_pix_word;
        r_row_addr  <= n_row_addr;
        r_pix_addr  <= n_pix_addr;
        r_size      <= n_size;
        r_out_addr  <= n_out_addr;
        r_out_data  <= n_out_data;
        r_out_size  <= n_out_size;
        r_out_last  <= n_out_last;
    end

    assign o_wr.valid      = r_out_valid;
    assign o_wr.write_addr = r_out_addr;
    assign o_wr.write_data = r_out_data;
    assign o_wr.write_size = r_out_size;
    assign o_wr.is_last    = r_out_last;

`ifndef SYNTHESIS
    // The final pixel of a fill ends it and is presented marked as last.
    a_last_ends_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_produce && w_last) |=> (!r_busy && r_out_valid && r_out_last))
        else $error("last pixel write did not end the fill");

    // An accepted beat that makes no write leaves the output register empty.
    a_no_spurious_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_produce) |=> !r_out_valid)
        else $error("write beat produced without a pending step");

    // The cursor never leaves the armed rectangle.
    a_cursor_in_rect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ((r_cur_col >= r_first_col) && (r_cur_col <= r_last_col)
                    && (r_cur_row <= r_last_row)))
        else $error("fill cursor outside the rectangle");

    // A fill is never armed with the unsupported format.
    a_fmt_supported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_size != rfw_pkg::FMT_NONE))
        else $error("fill armed with unsupported pixel format");
`endif

endmodule
